>>> sv/scc_pkg.sv
// Shared constants for the strongly connected components block.
// No dependencies; used by the top level, its checker and the bench.
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 256;
  localparam int VertexW     = 6;   // vertex and component fields
  localparam int CountW      = 7;   // vertex_count and component_total
  localparam int InDataW     = 16;  // source, target, zero fill
  localparam int OutDataW    = 24;  // vertex, component, total, dropped, zero fill
  localparam logic [CountW-1:0] VertexCountRst = CountW'(64);
endpackage
`default_nettype wire

>>> sv/strongly_connected_components_top.sv
// Tarjan strongly connected components over a streamed edge list.
// Depends on scc_pkg; memories are synchronous with registered reads; the rest sits in flops.
`timescale 1ns / 1ps
`default_nettype none
// Usage notes:
//  - Slave stream carries one edge word: tdata = source, target; tuser = edge
//    present; tlast marks the last word of the graph and starts the search.
//  - Out-of-range edges and edges past MAX_EDGES are dropped and flagged.
//  - After the search one word per vertex leaves on the master stream, in
//    vertex order, with its component, the component total and the drop flag;
//    tlast marks the last vertex.
//  - Edge words are accepted whenever the block is loading. The search
//    scans edge slots one by one and fetches an on-stack neighbour's low
//    link in an extra wait state: each frame walks the whole raw edge
//    memory for its own source through a registered read port.
//  - Input is not taken while a search runs or results are pending; a stalled
//    result word simply holds, nothing else moves.
//  - Reset empties the edge memory count, clears the drop flag and restores
//    vertex_count to 64. No memory clearing pass is needed.
//  - The user writes vertex_count only while the block is idle; the block does not enforce it.
module strongly_connected_components_top #(
  parameter int MAX_VERTICES = scc_pkg::MaxVertices,
  parameter int MAX_EDGES    = scc_pkg::MaxEdges
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [scc_pkg::CountW-1:0]    cfg_wdata_i,   // vertex_count
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [scc_pkg::InDataW-1:0]   s_axis_tdata_i, // [5:0] source, [11:6] target
  input  wire logic                          s_axis_tuser_i, // edge_present
  input  wire logic                          s_axis_tlast_i, // final_edge
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [scc_pkg::OutDataW-1:0]       m_axis_tdata_o, // [5:0] vertex, [11:6] component,
                                                             // [18:12] total, [19] dropped
  output logic                               m_axis_tlast_o  // final_vertex
);
  import scc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FW = VW + EW + VW + VW;
  localparam logic [EW-1:0]   EdgeCap = EW'(MAX_EDGES);
  localparam logic [VW:0]     VertCap = (VW + 1)'(MAX_VERTICES);

  typedef enum logic [3:0] {
    ST_LOAD, ST_ROOT, ST_SCAN, ST_SCAN_W, ST_LOW_W, ST_FINISH,
    ST_POP, ST_POP_W, ST_RET, ST_RET_W, ST_EMIT_RD, ST_EMIT_W
  } state_e;

  state_e state_q;
  logic [CountW-1:0] vcount_q;
  logic [EW-1:0]     etotal_q;
  logic              ovf_q;
  logic [MAX_VERTICES-1:0] visited_q, onstk_q;
  logic [VW:0]       root_q, vc_q, cc_q, ptop_q, depth_q, oi_q;
  logic [VW-1:0]     cur_u_q, cur_low_q, cur_disc_q;
  logic [EW-1:0]     cur_pos_q;

  // memories
  logic [2*VertexW-1:0] raw_mem [MAX_EDGES];
  logic [VW-1:0]        low_mem [MAX_VERTICES];
  logic [VW-1:0]        ps_mem  [MAX_VERTICES];
  logic [VW-1:0]        comp_mem[MAX_VERTICES];
  logic [FW-1:0]        fr_mem  [MAX_VERTICES];
  logic [2*VertexW-1:0] raw_rd_q;
  logic [VW-1:0]        low_rd_q, ps_rd_q, comp_rd_q;
  logic [FW-1:0]        fr_rd_q;

  // effective vertex count
  logic [VW:0] n_c;
  always_comb begin
    if (vcount_q == '0) n_c = (VW + 1)'(1);
    else if ({1'b0, vcount_q} > (CountW + 1)'(VertCap)) n_c = VertCap;
    else n_c = (VW + 1)'(vcount_q);
  end

  logic [VertexW-1:0] in_s, in_t, sc_s, sc_t;
  assign in_s = s_axis_tdata_i[VertexW-1:0];
  assign in_t = s_axis_tdata_i[2*VertexW-1:VertexW];
  assign sc_t = raw_rd_q[VertexW-1:0];
  assign sc_s = raw_rd_q[2*VertexW-1:VertexW];

  logic in_acc, in_ok, sc_own, sc_tin;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign in_ok  = ({1'b0, in_s} < (VertexW + 1)'(n_c)) && ({1'b0, in_t} < (VertexW + 1)'(n_c))
                  && (etotal_q < EdgeCap);
  assign sc_own = ({1'b0, sc_s} < (VertexW + 1)'(n_c)) && (sc_s[VW-1:0] == cur_u_q)
                  && (sc_s >> VW == '0);
  assign sc_tin = {1'b0, sc_t} < (VertexW + 1)'(n_c);

  logic [VW-1:0] tgt;
  assign tgt = sc_t[VW-1:0];

  // memory writes
  logic          raw_we, low_we, ps_we, comp_we, fr_we;
  logic [VW-1:0] low_waddr, low_wdata, ps_wdata;
  always_comb begin
    raw_we    = in_acc && s_axis_tuser_i && in_ok;
    fr_we     = (state_q == ST_SCAN_W) && sc_own && sc_tin && !visited_q[tgt];
    low_we    = fr_we || (state_q == ST_FINISH);
    low_waddr = cur_u_q;
    low_wdata = cur_low_q;
    ps_we     = fr_we || ((state_q == ST_ROOT) && (root_q != n_c)
                          && !visited_q[root_q[VW-1:0]]);
    ps_wdata  = fr_we ? tgt : root_q[VW-1:0];
    comp_we   = (state_q == ST_POP_W);
  end

  always_ff @(posedge clk_i) begin
    if (raw_we) raw_mem[etotal_q[AW-1:0]] <= {in_s, in_t};
    raw_rd_q <= raw_mem[cur_pos_q[AW-1:0]];
  end
  always_ff @(posedge clk_i) begin
    if (low_we) low_mem[low_waddr] <= low_wdata;
    low_rd_q <= low_mem[tgt];
  end
  always_ff @(posedge clk_i) begin
    if (ps_we) ps_mem[ptop_q[VW-1:0]] <= ps_wdata;
    ps_rd_q <= ps_mem[VW'(ptop_q - 1'b1)];
  end
  always_ff @(posedge clk_i) begin
    if (comp_we) comp_mem[ps_rd_q] <= cc_q[VW-1:0];
    comp_rd_q <= comp_mem[oi_q[VW-1:0]];
  end
  always_ff @(posedge clk_i) begin
    if (fr_we) fr_mem[depth_q[VW-1:0]] <= {cur_u_q, cur_pos_q, cur_low_q, cur_disc_q};
    fr_rd_q <= fr_mem[VW'(depth_q - 1'b1)];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      vcount_q   <= VertexCountRst;
      etotal_q   <= '0;
      ovf_q      <= 1'b0;
      visited_q  <= '0;
      onstk_q    <= '0;
      root_q     <= '0;
      vc_q       <= '0;
      cc_q       <= '0;
      ptop_q     <= '0;
      depth_q    <= '0;
      oi_q       <= '0;
      cur_u_q    <= '0;
      cur_low_q  <= '0;
      cur_disc_q <= '0;
      cur_pos_q  <= '0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (s_axis_tuser_i) begin
              if (in_ok) etotal_q <= etotal_q + 1'b1;
              else ovf_q <= 1'b1;
            end
            if (s_axis_tlast_i) begin
              visited_q <= '0;
              onstk_q   <= '0;
              root_q    <= '0;
              vc_q      <= '0;
              cc_q      <= '0;
              ptop_q    <= '0;
              depth_q   <= '0;
              state_q   <= ST_ROOT;
            end
          end
        end
        ST_ROOT: begin
          if (root_q == n_c) begin
            oi_q    <= '0;
            state_q <= ST_EMIT_RD;
          end else if (visited_q[root_q[VW-1:0]]) begin
            root_q <= root_q + 1'b1;
          end else begin
            visited_q[root_q[VW-1:0]] <= 1'b1;
            onstk_q[root_q[VW-1:0]]   <= 1'b1;
            ptop_q     <= ptop_q + 1'b1;
            cur_u_q    <= root_q[VW-1:0];
            cur_pos_q  <= '0;
            cur_low_q  <= vc_q[VW-1:0];
            cur_disc_q <= vc_q[VW-1:0];
            vc_q       <= vc_q + 1'b1;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          state_q <= (cur_pos_q == etotal_q) ? ST_FINISH : ST_SCAN_W;
        end
        ST_SCAN_W: begin
          if (!sc_own || !sc_tin) begin
            cur_pos_q <= cur_pos_q + 1'b1;
            state_q   <= ST_SCAN;
          end else if (!visited_q[tgt]) begin
            // descend: parent frame saved by the memory write this cycle
            depth_q          <= depth_q + 1'b1;
            visited_q[tgt]   <= 1'b1;
            onstk_q[tgt]     <= 1'b1;
            ptop_q           <= ptop_q + 1'b1;
            cur_u_q          <= tgt;
            cur_pos_q        <= '0;
            cur_low_q        <= vc_q[VW-1:0];
            cur_disc_q       <= vc_q[VW-1:0];
            vc_q             <= vc_q + 1'b1;
            state_q          <= ST_SCAN;
          end else if (onstk_q[tgt] && (tgt != cur_u_q)) begin
            state_q <= ST_LOW_W;
          end else begin
            cur_pos_q <= cur_pos_q + 1'b1;
            state_q   <= ST_SCAN;
          end
        end
        ST_LOW_W: begin
          if (low_rd_q < cur_low_q) cur_low_q <= low_rd_q;
          cur_pos_q <= cur_pos_q + 1'b1;
          state_q   <= ST_SCAN;
        end
        ST_FINISH: begin
          state_q <= (cur_low_q == cur_disc_q) ? ST_POP : ST_RET;
        end
        ST_POP: begin
          state_q <= (ptop_q == '0) ? ST_RET : ST_POP_W;
        end
        ST_POP_W: begin
          onstk_q[ps_rd_q] <= 1'b0;
          ptop_q           <= ptop_q - 1'b1;
          if (ps_rd_q == cur_u_q) begin
            cc_q    <= cc_q + 1'b1;
            state_q <= ST_RET;
          end else begin
            state_q <= ST_POP;
          end
        end
        ST_RET: begin
          if (depth_q == '0) begin
            root_q  <= root_q + 1'b1;
            state_q <= ST_ROOT;
          end else begin
            state_q <= ST_RET_W;
          end
        end
        ST_RET_W: begin
          {cur_u_q, cur_pos_q, cur_low_q, cur_disc_q} <= fr_rd_q;
          depth_q <= depth_q - 1'b1;
          state_q <= ST_SCAN;
        end
        ST_EMIT_RD: state_q <= ST_EMIT_W;
        ST_EMIT_W: begin
          if (m_axis_tready_i) begin
            if (oi_q + 1'b1 == n_c) begin
              etotal_q <= '0;
              ovf_q    <= 1'b0;
              state_q  <= ST_LOAD;
            end else begin
              oi_q    <= oi_q + 1'b1;
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign m_axis_tvalid_o = (state_q == ST_EMIT_W);
  assign m_axis_tlast_o  = (oi_q + 1'b1 == n_c);
  assign m_axis_tdata_o  = {4'b0, ovf_q, CountW'(cc_q), VertexW'(comp_rd_q), VertexW'(oi_q)};
endmodule
`default_nettype wire

>>> sv/scc_chk.sv
// Port-level checker for the strongly connected components block.
// Depends on scc_pkg; bound to strongly_connected_components_top below.
`timescale 1ns / 1ps
`default_nettype none
module scc_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tready_o,
  input wire logic                        m_axis_tvalid_o,
  input wire logic                        m_axis_tready_i,
  input wire logic [scc_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic                        m_axis_tlast_o
);

  // input side closed while results are out
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o) else $error("input open during results");

  // component number below component total
  a_comp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ({1'b0, m_axis_tdata_o[11:6]} < m_axis_tdata_o[18:12]))
    else $error("component out of range");

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed under stall");

  // last result word returns the block to loading
  a_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> s_axis_tready_o)
    else $error("no return to loading after last word");
endmodule

bind strongly_connected_components_top scc_chk u_scc_chk (.*);
`default_nettype wire

>>> bench/tb_strongly_connected_components_top.sv
// Self-checking bench for strongly_connected_components_top: edge words in, vertex words out.
// Depends on scc_pkg and the top level; holds its own Tarjan predictor.
`timescale 1ns / 1ps
module tb_strongly_connected_components_top;
  import scc_pkg::*;

  localparam int StallLimit = 200000;  // idle cycles allowed before the watchdog stops the run

  typedef struct packed {
    logic             present;
    logic [5:0]       src;
    logic [5:0]       dst;
    logic             last;
  } edge_word_t;

  typedef struct packed {
    logic [5:0]        vertex;
    logic [5:0]        comp;
    logic [CountW-1:0] total;
    logic              dropped;
    logic              last;
  } vertex_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [InDataW-1:0] s_data = '0;
  logic s_user = 1'b0;
  logic s_last = 1'b0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic m_last;

  strongly_connected_components_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  edge_word_t   pending_edges[$];
  vertex_word_t expected_vertices[$];
  int  err_count = 0;
  bit  calm = 1'b0;      // no idling on either side while set
  int  quiet_cycles = 0;

  // predictor state
  logic [6:0]  vtx_count_reg = 7'd64;
  logic [11:0] edge_mem[MaxEdges];
  int          edge_cnt = 0;
  bit          drop_seen = 1'b0;

  // Tarjan over the held edges, iterative, completion-order numbering
  function automatic void predict_components();
    int n, i, s, top, depth, visits, comps, u, v, pos, w, f;
    int start[MaxVertices+1];
    int fill[MaxVertices];
    int nbr[MaxEdges];
    int disc[MaxVertices];
    int low[MaxVertices];
    bit on_stk[MaxVertices];
    int comp_of[MaxVertices];
    int stk[MaxVertices];
    int fr_v[MaxVertices];
    int fr_p[MaxVertices];
    vertex_word_t r;
    n = (vtx_count_reg == 0) ? 1 : (vtx_count_reg > MaxVertices ? MaxVertices : vtx_count_reg);
    for (i = 0; i <= MaxVertices; i++) start[i] = 0;
    for (i = 0; i < edge_cnt; i++) begin
      s = edge_mem[i][11:6];
      if (s < n) start[s+1]++;
    end
    for (i = 0; i < n; i++) start[i+1] += start[i];
    for (i = 0; i < n; i++) fill[i] = start[i];
    for (i = 0; i < edge_cnt; i++) begin
      s = edge_mem[i][11:6];
      if (s < n) begin
        nbr[fill[s]] = edge_mem[i][5:0];
        fill[s]++;
      end
    end
    for (i = 0; i < MaxVertices; i++) begin
      disc[i] = -1; low[i] = 0; on_stk[i] = 0; comp_of[i] = 0;
    end
    top = 0; depth = 0; visits = 0; comps = 0;
    for (i = 0; i < n; i++) begin
      if (disc[i] != -1) continue;
      disc[i] = visits; low[i] = visits; visits++;
      stk[top++] = i; on_stk[i] = 1;
      fr_v[depth] = i; fr_p[depth] = start[i]; depth++;
      while (depth > 0) begin
        f = depth - 1;
        u = fr_v[f];
        pos = fr_p[f];
        if (pos < start[u+1]) begin
          v = nbr[pos];
          if (v >= n) begin
            fr_p[f] = pos + 1;
            continue;
          end
          if (disc[v] == -1) begin
            disc[v] = visits; low[v] = visits; visits++;
            stk[top++] = v; on_stk[v] = 1;
            fr_v[depth] = v; fr_p[depth] = start[v]; depth++;
            continue;
          end
          if (on_stk[v] && low[v] < low[u]) low[u] = low[v];
          fr_p[f] = pos + 1;
          continue;
        end
        if (low[u] == disc[u]) begin
          do begin
            top--;
            w = stk[top];
            on_stk[w] = 0;
            comp_of[w] = comps;
          end while (w != u);
          comps++;
        end
        depth--;
      end
    end
    for (i = 0; i < n; i++) begin
      r.vertex  = 6'(i);
      r.comp    = 6'(comp_of[i]);
      r.total   = CountW'(comps);
      r.dropped = drop_seen;
      r.last    = (i == n - 1);
      expected_vertices.insert(expected_vertices.size(), r);
    end
    edge_cnt  = 0;
    drop_seen = 1'b0;
  endfunction

  function automatic void absorb_edge(edge_word_t e);
    int n;
    n = (vtx_count_reg == 0) ? 1 : (vtx_count_reg > MaxVertices ? MaxVertices : vtx_count_reg);
    if (e.present) begin
      if (e.src >= n || e.dst >= n || edge_cnt >= MaxEdges) drop_seen = 1'b1;
      else edge_mem[edge_cnt++] = {e.src, e.dst};
    end
    if (e.last) predict_components();
  endfunction

  // driver: input side
  always @(posedge clk_i) begin
    edge_word_t e;
    if (s_valid && s_ready)
      absorb_edge('{s_user, s_data[5:0], s_data[11:6], s_last});
    if (!(s_valid && !s_ready)) begin
      if (rst_ni && pending_edges.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
        e = pending_edges.pop_front();
        s_valid <= 1'b1;
        s_data  <= {4'b0, e.dst, e.src};
        s_user  <= e.present;
        s_last  <= e.last;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // monitor: result side
  always @(posedge clk_i) begin
    vertex_word_t exp_w;
    if (m_valid && m_ready) begin
      if (expected_vertices.size() == 0) begin
        $error("unexpected vertex word %h", m_data);
        err_count++;
      end else begin
        exp_w = expected_vertices.pop_front();
        if (m_data[5:0] !== exp_w.vertex) begin
          $error("vertex: exp %0d got %0d", exp_w.vertex, m_data[5:0]); err_count++;
        end
        if (m_data[11:6] !== exp_w.comp) begin
          $error("component: exp %0d got %0d", exp_w.comp, m_data[11:6]); err_count++;
        end
        if (m_data[18:12] !== exp_w.total) begin
          $error("component_total: exp %0d got %0d", exp_w.total, m_data[18:12]); err_count++;
        end
        if (m_data[19] !== exp_w.dropped) begin
          $error("dropped_edges: exp %0d got %0d", exp_w.dropped, m_data[19]); err_count++;
        end
        if (m_last !== exp_w.last) begin
          $error("final_vertex: exp %0d got %0d", exp_w.last, m_last); err_count++;
        end
      end
    end
    m_ready <= calm || $urandom_range(99) >= 24;
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("tb_strongly_connected_components_top NOT OK");
      $finish;
    end
  end

  task automatic put_edge(bit present, int src, int dst, bit last);
    edge_word_t e;
    e = '{present, 6'(src), 6'(dst), last};
    pending_edges.insert(pending_edges.size(), e);
  endtask

  // random graph: edges mostly inside a small span so cycles form, some noise
  task automatic put_graph(int n_edges, int span);
    int k, s, d;
    for (k = 0; k < n_edges; k++) begin
      if ($urandom_range(9) == 0) begin
        s = $urandom_range(63); d = $urandom_range(63);
      end else begin
        s = $urandom_range(span - 1); d = $urandom_range(span - 1);
      end
      put_edge($urandom_range(9) != 0, s, d, k == n_edges - 1);
    end
  endtask

  task automatic drain();
    while (pending_edges.size() > 0 || expected_vertices.size() > 0 || s_valid)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_count(int value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CountW'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    vtx_count_reg = 7'(value);
    @(posedge clk_i);
  endtask

  initial begin
    int cfgs[7] = '{1, 7, 127, 20, 0, 33, 64};
    int p, g, span;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset count of 64: 0 and 1 reach each other, self loop at the top vertex, empty word
    put_edge(1, 0, 1, 0);
    put_edge(1, 1, 0, 0);
    put_edge(1, 63, 63, 0);
    put_edge(0, 63, 63, 0);
    put_edge(1, 2, 0, 1);
    put_edge(0, 0, 0, 1);        // graph with no edges at all
    drain();

    // three vertices: ring plus out-of-range source and target
    write_count(3);
    put_edge(1, 5, 0, 0);
    put_edge(1, 0, 3, 0);
    put_edge(1, 0, 1, 0);
    put_edge(1, 1, 2, 0);
    put_edge(1, 2, 0, 1);
    put_edge(1, 2, 1, 1);        // edge carried on the final word only
    drain();

    // zero acts as one vertex
    write_count(0);
    put_edge(1, 0, 0, 0);
    put_edge(1, 1, 0, 1);
    drain();

    // above the maximum acts as 64; chain 0..4 forward, one back edge
    write_count(127);
    for (int k = 0; k < 4; k++) put_edge(1, k, k + 1, 0);
    put_edge(1, 4, 2, 1);
    drain();

    // edge store overflow
    write_count(64);
    calm = 1'b1;
    for (int k = 0; k < 258; k++)
      put_edge(1, $urandom_range(63), $urandom_range(63), k == 257);
    drain();
    calm = 1'b0;

    for (p = 0; p < 7; p++) begin
      write_count(cfgs[p]);
      calm = (p == 3);
      for (g = 0; g < 3; g++) begin
        span = (cfgs[p] == 0) ? 2 : (cfgs[p] > 64 ? 12 : (cfgs[p] < 12 ? cfgs[p] + 1 : 12));
        put_graph($urandom_range(4, 14), span);
      end
      drain();
    end
    calm = 1'b0;

    repeat (100) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_strongly_connected_components_top OK");
    end else begin
      $display("tb_strongly_connected_components_top NOT OK");
    end
    $finish;
  end

endmodule
